// ===== rtl/handshake_fragment_reassembly_core_defines.svh =====
// ----------------------------------------------------------------------------
// handshake_fragment_reassembly_core_defines
// Assertion macros used by the checker file of the reassembly core.
// ----------------------------------------------------------------------------
`ifndef HANDSHAKE_FRAGMENT_REASSEMBLY_CORE_DEFINES_SVH
`define HANDSHAKE_FRAGMENT_REASSEMBLY_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HFR_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HFR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/hfr_pkg.sv =====
// ----------------------------------------------------------------------------
// hfr_pkg
// Types and constants shared by the handshake fragment reassembly modules.
// ----------------------------------------------------------------------------
package hfr_pkg;

  localparam int OUT_LEN_W = 12;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DROPPED   = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_OVERRUN   = 3'd3;
  localparam logic [2:0] ST_NO_SLOT   = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;
  localparam logic [2:0] ST_NOT_READY = 3'd6;

  localparam logic       OP_APPEND = 1'b0;
  localparam logic       OP_FETCH  = 1'b1;

  // Register index bit of the configuration address (byte address 4*i).
  localparam logic       REG_WINDOW   = 1'b0;
  localparam logic [7:0] WINDOW_RESET = 8'd10;

  typedef struct packed {
    logic        opcode;
    logic [15:0] expected_seq;
    logic [15:0] msg_seq;
    logic [7:0]  msg_type;
    logic [23:0] msg_length;
    logic [23:0] frag_offset;
    logic [23:0] frag_length;
  } in_t;

  typedef struct packed {
    logic [2:0]           status;
    logic                 complete;
    logic [7:0]           out_type;
    logic [OUT_LEN_W-1:0] out_length;
    logic [15:0]          out_seq;
  } out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic eval;
    logic clear;
    logic check;
    logic walk;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic eval_alloc;
    logic eval_check;
    logic clear_last;
    logic chk_walk;
    logic walk_done;
  } sts_t;

endpackage

// ===== rtl/handshake_fragment_reassembly_core.sv =====
// ----------------------------------------------------------------------------
// handshake_fragment_reassembly_core
// Coverage tracker for fragmented handshake messages in a fixed slot table.
// ----------------------------------------------------------------------------
// Usage: raise start with an item on in_data while busy is low; the item is
// taken at that edge and busy rises. Each item gives exactly one result,
// shown on out_data for one cycle with out_valid high; busy has fallen again
// by then, so the next item may follow in the same cycle.
// Steps: load, a scan of every slot and a decision, where a drop or fetch
// ends; for a new message a bitmap clear; then a check and a walk over the
// words of the message. The result is registered. The bitmap memory port,
// one word a cycle, sets the walk and clear lengths.
// The window_ahead register sits at byte address 0 of the APB port.
// Reset empties the slot table and sets window_ahead to 10; the bitmap is
// cleared per slot when the slot is taken. Results cannot be held off.
// ----------------------------------------------------------------------------
module handshake_fragment_reassembly_core #(
  parameter int SLOTS       = 16,
  parameter int MAX_MSG_LEN = 2048,
  parameter int BITMAP_WORD = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  hfr_pkg::in_t  in_data,
  output logic          out_valid,
  output hfr_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  hfr_pkg::cmd_t cmd;
  hfr_pkg::sts_t sts;
  logic [7:0]    window_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= hfr_pkg::WINDOW_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == hfr_pkg::REG_WINDOW)) begin
      window_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == hfr_pkg::REG_WINDOW) ? {24'd0, window_r} : 32'd0;

  hfr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  hfr_datapath #(
    .SLOTS       (SLOTS),
    .MAX_MSG_LEN (MAX_MSG_LEN),
    .BITMAP_WORD (BITMAP_WORD)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .window    (window_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/hfr_ram.sv =====
// ----------------------------------------------------------------------------
// hfr_ram
// Generic one-write, one-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module hfr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/hfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// hfr_ctrl
// Sequencer: slot scan, decision, bitmap clear, check and bitmap walk.
// ----------------------------------------------------------------------------
module hfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  hfr_pkg::sts_t sts,
  output hfr_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_CLEAR = 6'b001000,
    S_CHECK = 6'b010000,
    S_WALK  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.eval_alloc) begin
          state_nxt = S_CLEAR;
        end else if (sts.eval_check) begin
          state_nxt = S_CHECK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.chk_walk ? S_WALK : S_IDLE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hfr_datapath.sv =====
// ----------------------------------------------------------------------------
// hfr_datapath
// Slot table, coverage bitmap memory, range marking and result register.
// ----------------------------------------------------------------------------
module hfr_datapath #(
  parameter int SLOTS       = 16,
  parameter int MAX_MSG_LEN = 2048,
  parameter int BITMAP_WORD = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hfr_pkg::cmd_t cmd,
  output hfr_pkg::sts_t sts,
  input  hfr_pkg::in_t  in_data,
  input  logic [7:0]    window,
  output logic          out_valid,
  output hfr_pkg::out_t out_data
);

  localparam int WORDS  = (MAX_MSG_LEN + BITMAP_WORD - 1) / BITMAP_WORD;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int AW     = $clog2(SLOTS * WORDS);
  localparam int LEN_W  = $clog2(MAX_MSG_LEN + 1);
  localparam int BASE_W = $clog2(MAX_MSG_LEN + BITMAP_WORD + 1);

  hfr_pkg::in_t in_r;

  logic              valid_r [SLOTS];
  logic              cpl_r   [SLOTS];
  logic [15:0]       seq_m   [SLOTS];
  logic [7:0]        type_m  [SLOTS];
  logic [LEN_W-1:0]  len_m   [SLOTS];

  logic [IDX_W-1:0]  idx_r, hit_idx_r, free_idx_r, sel_r, rd_idx;
  logic              hit_r, free_r;
  logic [15:0]       key;
  logic              match;

  logic [7:0]        ty_rd;
  logic [LEN_W-1:0]  len_rd;

  logic              drop, too_long, fetch_ok;
  logic              mism, len0, overrun;

  logic [WIDX_W-1:0] w_r;
  logic [BASE_W-1:0] base_r, pend_base_r, base_nxt;
  logic              issue_r, pend_r, ok_r, mark_en_r;
  logic [AW-1:0]     pend_addr_r, cur_addr;
  logic [LEN_W-1:0]  first_r, last_r, len_r;
  logic [23:0]       last_full;

  logic [BASE_W-1:0] first_ext, last_ext, len_ext, lo, hi, rem;
  logic              word_hit;
  logic [BITMAP_WORD-1:0] set_mask, exp_mask, new_word, ram_rdata;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [BITMAP_WORD-1:0] ram_wdata;

  logic              emit;
  hfr_pkg::out_t     res_nxt;
  logic              walk_cpl;

  // --------------------------------------------------------------------------
  // Slot scan
  // --------------------------------------------------------------------------
  assign key   = (in_r.opcode == hfr_pkg::OP_FETCH) ? in_r.expected_seq : in_r.msg_seq;
  assign match = valid_r[idx_r] && (seq_m[idx_r] == key);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.load) begin
      idx_r  <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + 1'b1;
      if (match && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (!valid_r[idx_r] && !free_r) begin
        free_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && match && !hit_r) begin
      hit_idx_r <= idx_r;
    end
    if (cmd.scan && !valid_r[idx_r] && !free_r) begin
      free_idx_r <= idx_r;
    end
  end

  assign sts.scan_last = (idx_r == IDX_W'(SLOTS - 1));

  // --------------------------------------------------------------------------
  // Decision after the scan
  // --------------------------------------------------------------------------
  assign rd_idx = cmd.eval ? hit_idx_r : sel_r;
  assign ty_rd  = type_m[rd_idx];
  assign len_rd = len_m[rd_idx];

  assign drop     = {1'b0, in_r.msg_seq} > ({1'b0, in_r.expected_seq} + {9'd0, window});
  assign too_long = in_r.msg_length > 24'(MAX_MSG_LEN);
  assign fetch_ok = hit_r && cpl_r[hit_idx_r];

  assign sts.eval_check = (in_r.opcode == hfr_pkg::OP_APPEND) && !drop && hit_r;
  assign sts.eval_alloc = (in_r.opcode == hfr_pkg::OP_APPEND) && !drop && !hit_r &&
                          !too_long && free_r;

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      sel_r <= hit_r ? hit_idx_r : free_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && sts.eval_alloc) begin
      seq_m[free_idx_r]  <= in_r.msg_seq;
      type_m[free_idx_r] <= in_r.msg_type;
      len_m[free_idx_r]  <= LEN_W'(in_r.msg_length);
    end
  end

  // --------------------------------------------------------------------------
  // Fragment check against the selected slot
  // --------------------------------------------------------------------------
  assign mism    = (ty_rd != in_r.msg_type) || (in_r.msg_length != 24'(len_rd)) ||
                   (in_r.frag_offset > 24'(len_rd));
  assign len0    = (len_rd == '0);
  assign overrun = in_r.frag_length > (24'(len_rd) - in_r.frag_offset);
  assign sts.chk_walk = !mism && !len0 && !overrun;

  assign last_full = in_r.frag_offset + in_r.frag_length - 24'd1;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      first_r   <= LEN_W'(in_r.frag_offset);
      last_r    <= LEN_W'(last_full);
      mark_en_r <= (in_r.frag_length != '0);
      len_r     <= len_rd;
    end
  end

  // --------------------------------------------------------------------------
  // Bitmap clear and walk. The walk reads every word of the message, ORs in
  // the fragment's bits and compares each word with its full-coverage mask.
  // --------------------------------------------------------------------------
  assign cur_addr = AW'(sel_r) * AW'(WORDS) + AW'(w_r);
  assign base_nxt = base_r + BASE_W'(BITMAP_WORD);
  assign sts.clear_last = (w_r == WIDX_W'(WORDS - 1));
  assign sts.walk_done  = !issue_r && !pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= '0;
      base_r  <= '0;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
      ok_r    <= 1'b0;
    end else if (cmd.eval) begin
      w_r <= '0;
    end else if (cmd.clear) begin
      w_r <= w_r + 1'b1;
    end else if (cmd.check) begin
      w_r     <= '0;
      base_r  <= '0;
      issue_r <= sts.chk_walk;
      pend_r  <= 1'b0;
      ok_r    <= 1'b1;
    end else if (cmd.walk) begin
      pend_r <= issue_r;
      if (issue_r) begin
        w_r     <= w_r + 1'b1;
        base_r  <= base_nxt;
        issue_r <= base_nxt < BASE_W'(len_r);
      end
      if (pend_r) begin
        ok_r <= ok_r && (new_word == exp_mask);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk && issue_r) begin
      pend_base_r <= base_r;
      pend_addr_r <= cur_addr;
    end
  end

  assign first_ext = BASE_W'(first_r);
  assign last_ext  = BASE_W'(last_r);
  assign len_ext   = BASE_W'(len_r);
  assign lo        = (first_ext > pend_base_r) ? (first_ext - pend_base_r) : '0;
  assign hi        = last_ext - pend_base_r;
  assign rem       = len_ext - pend_base_r;
  assign word_hit  = mark_en_r && (last_ext >= pend_base_r);

  always_comb begin
    for (int b = 0; b < BITMAP_WORD; b++) begin
      set_mask[b] = word_hit && (BASE_W'(b) >= lo) && (BASE_W'(b) <= hi);
      exp_mask[b] = BASE_W'(b) < rem;
    end
  end

  assign new_word = ram_rdata | set_mask;

  assign ram_re    = cmd.walk && issue_r;
  assign ram_we    = cmd.clear || (cmd.walk && pend_r);
  assign ram_waddr = cmd.clear ? cur_addr : pend_addr_r;
  assign ram_wdata = cmd.clear ? '0 : new_word;

  hfr_ram #(
    .WIDTH (BITMAP_WORD),
    .DEPTH (SLOTS * WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cur_addr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Slot flags
  // --------------------------------------------------------------------------
  assign walk_cpl = cpl_r[sel_r] || ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SLOTS; s++) begin
        valid_r[s] <= 1'b0;
        cpl_r[s]   <= 1'b0;
      end
    end else begin
      if (cmd.eval && sts.eval_alloc) begin
        valid_r[free_idx_r] <= 1'b1;
        cpl_r[free_idx_r]   <= 1'b0;
      end
      if (cmd.eval && (in_r.opcode == hfr_pkg::OP_FETCH) && fetch_ok) begin
        valid_r[hit_idx_r] <= 1'b0;
        cpl_r[hit_idx_r]   <= 1'b0;
      end
      if (cmd.check && !mism && len0) begin
        cpl_r[sel_r] <= 1'b1;
      end
      if (cmd.walk && sts.walk_done && ok_r) begin
        cpl_r[sel_r] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_comb begin
    emit            = 1'b0;
    res_nxt         = '0;
    res_nxt.out_seq = in_r.msg_seq;
    if (cmd.eval) begin
      if (in_r.opcode == hfr_pkg::OP_FETCH) begin
        emit            = 1'b1;
        res_nxt.out_seq = in_r.expected_seq;
        if (fetch_ok) begin
          res_nxt.status     = hfr_pkg::ST_OK;
          res_nxt.complete   = 1'b1;
          res_nxt.out_type   = ty_rd;
          res_nxt.out_length = hfr_pkg::OUT_LEN_W'(len_rd);
        end else begin
          res_nxt.status = hfr_pkg::ST_NOT_READY;
        end
      end else if (drop) begin
        emit           = 1'b1;
        res_nxt.status = hfr_pkg::ST_DROPPED;
      end else if (!hit_r && too_long) begin
        emit           = 1'b1;
        res_nxt.status = hfr_pkg::ST_TOO_LONG;
      end else if (!hit_r && !free_r) begin
        emit           = 1'b1;
        res_nxt.status = hfr_pkg::ST_NO_SLOT;
      end
    end else if (cmd.check) begin
      if (mism) begin
        emit           = 1'b1;
        res_nxt.status = hfr_pkg::ST_INVALID;
      end else if (len0) begin
        emit             = 1'b1;
        res_nxt.status   = hfr_pkg::ST_OK;
        res_nxt.complete = 1'b1;
        res_nxt.out_type = ty_rd;
      end else if (overrun) begin
        emit           = 1'b1;
        res_nxt.status = hfr_pkg::ST_OVERRUN;
      end
    end else if (cmd.walk && sts.walk_done) begin
      emit             = 1'b1;
      res_nxt.status   = hfr_pkg::ST_OK;
      res_nxt.complete = walk_cpl;
      res_nxt.out_type = ty_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= res_nxt;
    end
  end

endmodule

// ===== rtl/hfr_checker.sv =====
// ----------------------------------------------------------------------------
// hfr_checker
// Port-level checks on the reassembly core, bound to the top level.
// ----------------------------------------------------------------------------
`include "handshake_fragment_reassembly_core_defines.svh"

module hfr_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input hfr_pkg::out_t out_data,
  input logic          pready
);

  `HFR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
  `HFR_ASSERT_NOW(a_result_idle, out_valid, !busy, "result shown while busy")
  `HFR_ASSERT_NEXT(a_single_result, out_valid, !out_valid, "result strobe lasted two cycles")
  `HFR_ASSERT_NOW(a_error_incomplete, out_valid && (out_data.status != hfr_pkg::ST_OK),
    !out_data.complete && (out_data.out_type == 8'd0), "error result carries message data")
  `HFR_ASSERT_NOW(a_pready, 1'b1, pready, "pready dropped")

endmodule

bind handshake_fragment_reassembly_core hfr_checker u_hfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data),
  .pready    (pready)
);
